@@ sv/bblur_pkg.sv @@
package bblur_pkg;

	// Field and datapath widths
	localparam int CH_W        = 8;
	localparam int ROW_W       = 16;
	localparam int OUT_COL_W   = 10;
	localparam int FW_W        = 11;
	localparam int SUM_W       = 12;
	localparam int NUM_W       = 13;
	localparam int CNT_W       = 4;
	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 17;
	localparam int PROD_W      = NUM_W + RECIP_W;

	// Register indexes as decoded from paddr[2]
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
	localparam logic [ROW_W-1:0] FRAME_HEIGHT_RESET = 16'd1024;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	// One line store entry: the pixel two rows up and the pixel one row up.
	typedef struct packed {
		pixel_t older;
		pixel_t prev;
	} line_pair_t;

	// Window indexed [column][row]; column 0 is the oldest, row 2 the current row.
	typedef pixel_t [2:0][2:0] window_t;

	// Position of an accepted pixel within the frame.
	typedef struct packed {
		logic r_ge1;
		logic r_ge2;
		logic row_last;
		logic c_ge1;
		logic c_ge2;
		logic c_last;
		logic w_ge2;
	} pos_flags_t;

	// One result to be computed: the part of the window in use and its coordinates.
	typedef struct packed {
		logic [1:0]           row_lo;
		logic [1:0]           col_lo;
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] column;
		logic                 frame_end;
	} emit_desc_t;

	typedef struct packed {
		logic [CH_W-1:0]      out_red;
		logic [CH_W-1:0]      out_green;
		logic [CH_W-1:0]      out_blue;
		logic [ROW_W-1:0]     out_row;
		logic [OUT_COL_W-1:0] out_column;
		logic                 frame_end;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EMIT
	} ctrl_state_t;

	// Rounded-up reciprocal of twice the count, scaled by 2**RECIP_SHIFT.
	// Exact floor division for every numerator the window can produce.
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		unique case (n)
			4'd1:    r = 17'd65536;
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd6:    r = 17'd10923;
			4'd9:    r = 17'd7282;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ sv/box_blur_3x3_edge_clipped.sv @@
// A result is offered on m_tvalid after its pixel has passed the load and emit states of
// the window control and the stage-one and stage-two registers of the mean unit. A new pixel
// waits until the line store read-modify-write is done and its 0 to 4 results have been issued.
// The output pipeline holds up to two results, so the next pixel is taken while they wait.
// Reset clears the frame counters and the window and sets both frame registers to 1024;
// the line stores are not cleared, since no result reads an entry before it is rewritten.
module box_blur_3x3_edge_clipped import bblur_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // out_red, out_green, out_blue, out_row, out_column, zeros
	output logic        m_tlast
);

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [FW_W-1:0]  frame_width_q;
	logic [ROW_W-1:0] frame_height_q;
	logic             cfg_wr;
	logic [COL_W-1:0] last_col;
	logic [ROW_W-1:0] last_row;
	pixel_t           in_pixel;
	logic             rd_en;
	logic [COL_W-1:0] rd_addr;
	line_pair_t       rd_data;
	logic             wr_en;
	logic [COL_W-1:0] wr_addr;
	line_pair_t       wr_data;
	logic             emit_valid;
	logic             emit_ready;
	emit_desc_t       emit_desc;
	window_t          window;
	result_t          result;

	// Configuration registers; any write restarts the frame.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// Last column and row in use, with zero taken as one and the width saturated.
	always_comb begin
		if (frame_width_q == '0) begin
			last_col = '0;
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			last_col = COL_W'(MAX_WIDTH - 1);
		end else begin
			last_col = COL_W'(frame_width_q - 1'b1);
		end
		last_row = (frame_height_q == '0) ? '0 : frame_height_q - 1'b1;
	end

	assign in_pixel.red   = s_tdata[7:0];
	assign in_pixel.green = s_tdata[15:8];
	assign in_pixel.blue  = s_tdata[23:16];

	bblur_line_store #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W)
	) u_line_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	bblur_window_ctrl #(
		.COL_W (COL_W)
	) u_window_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_wr),
		.last_col   (last_col),
		.last_row   (last_row),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_pixel   (in_pixel),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.emit_valid (emit_valid),
		.emit_ready (emit_ready),
		.emit_desc  (emit_desc),
		.window     (window)
	);

	bblur_mean u_mean (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (emit_valid),
		.in_ready   (emit_ready),
		.in_desc    (emit_desc),
		.in_window  (window),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = {6'd0, result.out_column, result.out_row,
	                  result.out_blue, result.out_green, result.out_red};
	assign m_tlast = result.frame_end;

	// No pixel is taken while results of the previous one are still being issued.
	a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit_valid && s_tready))
		else $error("pixel accepted while results are being issued");

	// Every write-back comes in the cycle after the read of the same entry.
	a_write_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ($past(rd_en) && (wr_addr == $past(rd_addr))))
		else $error("line store write without matching read");

	// A read is never issued in the same cycle as a write-back.
	a_no_read_during_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("line store read overlaps write-back");

endmodule

@@ sv/bblur_line_store.sv @@
module bblur_line_store import bblur_pkg::*; #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output line_pair_t        rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  line_pair_t        wr_data
);

	line_pair_t mem [DEPTH];

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

@@ sv/bblur_window_ctrl.sv @@
module bblur_window_ctrl import bblur_pkg::*; #(
	parameter int COL_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  logic [COL_W-1:0] last_col,
	input  logic [ROW_W-1:0] last_row,
	input  logic             in_valid,
	output logic             in_ready,
	input  pixel_t           in_pixel,
	output logic             rd_en,
	output logic [COL_W-1:0] rd_addr,
	input  line_pair_t       rd_data,
	output logic             wr_en,
	output logic [COL_W-1:0] wr_addr,
	output line_pair_t       wr_data,
	output logic             emit_valid,
	input  logic             emit_ready,
	output emit_desc_t       emit_desc,
	output window_t          window
);

	ctrl_state_t      state_q, state_d;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	pixel_t           pix_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	pos_flags_t       flags;
	pos_flags_t       flags_s1;
	logic [3:0]       pend_q;
	logic [3:0]       pend_load;
	logic [3:0]       pend_rest;
	window_t          window_q;
	logic             accept;
	logic             emit_upper;
	logic             emit_right;

	// Position of the pixel about to be accepted.
	always_comb begin
		flags.r_ge1    = row_q != '0;
		flags.r_ge2    = row_q > ROW_W'(1);
		flags.row_last = row_q == last_row;
		flags.c_ge1    = col_q != '0;
		flags.c_ge2    = (col_q != '0) && (col_q != COL_W'(1));
		flags.c_last   = col_q == last_col;
		flags.w_ge2    = last_col != '0;
	end

	// Results due for the loaded pixel, lowest bit first:
	// upper-left, upper row end, last-row left, last-row end.
	assign pend_load = {flags_s1.row_last & flags_s1.c_last,
	                    flags_s1.row_last & flags_s1.c_ge1,
	                    flags_s1.r_ge1 & flags_s1.c_last,
	                    flags_s1.r_ge1 & flags_s1.c_ge1};
	assign pend_rest = pend_q & (pend_q - 4'd1);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control outputs.
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		emit_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					rd_en   = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				wr_en   = 1'b1;
				state_d = (pend_load != '0) ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				emit_valid = 1'b1;
				if (emit_ready && (pend_rest == '0)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = in_valid & in_ready;

	// Frame position counters; a register write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (flags.c_last) begin
				col_q <= '0;
				row_q <= flags.row_last ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Pending results and the window, which shifts in the column read back.
	// Within a column, row 0 is the older line, row 1 the previous line, row 2 the new pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			window_q <= '0;
		end else if (state_q == ST_LOAD) begin
			pend_q      <= pend_load;
			window_q[0] <= window_q[1];
			window_q[1] <= window_q[2];
			window_q[2] <= {pix_s1, rd_data.prev, rd_data.older};
		end else if (emit_valid && emit_ready) begin
			pend_q <= pend_rest;
		end
	end

	// Accepted pixel and its position.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= in_pixel;
			row_s1   <= row_q;
			col_s1   <= col_q;
			flags_s1 <= flags;
		end
	end

	// Read the column, then write it back shifted up by one row.
	assign rd_addr       = col_q;
	assign wr_addr       = col_s1;
	assign wr_data.older = rd_data.prev;
	assign wr_data.prev  = pix_s1;

	// Describe the lowest pending result.
	always_comb begin
		emit_upper = pend_q[0] | pend_q[1];
		emit_right = !pend_q[0] && (pend_q[1] || !pend_q[2]);
		if (emit_upper) begin
			emit_desc.row_lo = flags_s1.r_ge2 ? 2'd0 : 2'd1;
			emit_desc.row    = row_s1 - 1'b1;
		end else begin
			emit_desc.row_lo = flags_s1.r_ge1 ? 2'd1 : 2'd2;
			emit_desc.row    = row_s1;
		end
		if (emit_right) begin
			emit_desc.col_lo = flags_s1.w_ge2 ? 2'd1 : 2'd2;
			emit_desc.column = OUT_COL_W'(col_s1);
		end else begin
			emit_desc.col_lo = flags_s1.c_ge2 ? 2'd0 : 2'd1;
			emit_desc.column = OUT_COL_W'(col_s1 - 1'b1);
		end
		emit_desc.frame_end = pend_q == 4'b1000;
	end

	assign window = window_q;

endmodule

@@ sv/bblur_mean.sv @@
module bblur_mean import bblur_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  emit_desc_t in_desc,
	input  window_t    in_window,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    out_result
);

	typedef logic [2:0][2:0][CH_W-1:0] plane_t;

	plane_t               plane_r, plane_g, plane_b;
	logic [SUM_W-1:0]     sum_r, sum_g, sum_b;
	logic [CNT_W-1:0]     cnt;
	logic                 valid_s1, valid_s2;
	logic [NUM_W-1:0]     num_r_s1, num_g_s1, num_b_s1;
	logic [CNT_W-1:0]     cnt_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [OUT_COL_W-1:0] column_s1;
	logic                 frame_end_s1;
	logic                 adv_s2;
	logic [RECIP_W-1:0]   rcp;
	logic [PROD_W-1:0]    prod_r, prod_g, prod_b;
	result_t              result_s2;

	// Sum of one channel over the columns and rows in use: columns first, then across.
	function automatic logic [SUM_W-1:0] plane_sum(input plane_t p, input logic [1:0] row_lo,
	                                               input logic [1:0] col_lo);
		logic [2:0][SUM_W-1:0] col_sum;
		logic [SUM_W-1:0]      total;
		total = '0;
		for (int i = 0; i < 3; i++) begin
			col_sum[i] = '0;
			for (int j = 0; j < 3; j++) begin
				if (j >= int'(row_lo)) begin
					col_sum[i] = col_sum[i] + SUM_W'(p[i][j]);
				end
			end
			if (i >= int'(col_lo)) begin
				total = total + col_sum[i];
			end
		end
		return total;
	endfunction

	// Split the window into channel planes.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				plane_r[i][j] = in_window[i][j].red;
				plane_g[i][j] = in_window[i][j].green;
				plane_b[i][j] = in_window[i][j].blue;
			end
		end
	end

	assign sum_r = plane_sum(plane_r, in_desc.row_lo, in_desc.col_lo);
	assign sum_g = plane_sum(plane_g, in_desc.row_lo, in_desc.col_lo);
	assign sum_b = plane_sum(plane_b, in_desc.row_lo, in_desc.col_lo);
	assign cnt   = CNT_W'(2'd3 - in_desc.row_lo) * CNT_W'(2'd3 - in_desc.col_lo);

	// Stalling pipeline: each stage advances when the next one is free or draining.
	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage one: numerator 2*sum + count for rounding half up.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			num_r_s1     <= {sum_r, 1'b0} + NUM_W'(cnt);
			num_g_s1     <= {sum_g, 1'b0} + NUM_W'(cnt);
			num_b_s1     <= {sum_b, 1'b0} + NUM_W'(cnt);
			cnt_s1       <= cnt;
			row_s1       <= in_desc.row;
			column_s1    <= in_desc.column;
			frame_end_s1 <= in_desc.frame_end;
		end
	end

	// Stage two: divide by twice the count through the reciprocal table.
	assign rcp    = recip(cnt_s1);
	assign prod_r = PROD_W'(num_r_s1) * PROD_W'(rcp);
	assign prod_g = PROD_W'(num_g_s1) * PROD_W'(rcp);
	assign prod_b = PROD_W'(num_b_s1) * PROD_W'(rcp);

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2.out_red    <= prod_r[RECIP_SHIFT +: CH_W];
			result_s2.out_green  <= prod_g[RECIP_SHIFT +: CH_W];
			result_s2.out_blue   <= prod_b[RECIP_SHIFT +: CH_W];
			result_s2.out_row    <= row_s1;
			result_s2.out_column <= column_s1;
			result_s2.frame_end  <= frame_end_s1;
		end
	end

	assign out_valid  = valid_s2;
	assign out_result = result_s2;

endmodule
